/* hw/rtl/ptc_pkg.sv */
// Shared types, constants and helpers for the pressure/temperature compensation block.
// Used by ptc_div_cell, ptc_divider and pressure_temperature_compensation.
package ptc_pkg;

    localparam int unsigned DIV_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Compensation constants
    localparam logic [31:0] T_OFFSET   = 32'd4000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;
    localparam logic [31:0] PRES_SCALE = 32'd50000;
    localparam logic [31:0] K_3038     = 32'd3038;
    localparam logic [31:0] K_M7357    = 32'hFFFF_E343;
    localparam logic [31:0] K_3791     = 32'd3791;
    localparam logic [31:0] T_MAX      = 32'h0000_7FFF;
    localparam logic [31:0] T_MIN      = 32'hFFFF_8000;
    localparam logic [31:0] P_MAX      = 32'd1048575;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [19:0]        pressure_pa;
        logic [1:0]         status;
    } result_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

/* hw/rtl/pressure_temperature_compensation.sv */
// Top level of the barometric pressure and temperature compensation pipeline.
// Depends on ptc_pkg and ptc_divider (which uses ptc_div_cell).
//
// Takes one raw temperature/pressure transaction per cycle while sample_stall
// is low and returns the compensated temperature (0.1 C) and pressure (Pa)
// with a status code, in order. The path runs through two divisions, each a
// chain of 32 one-bit restoring cells, plus 13 stages of multiplies and adds
// around them. The whole pipeline holds while a finished result waits on
// result_stall, so sample_stall follows it. Calibration words are read live by
// the stages that use them: write them only while no transaction is in flight.
module pressure_temperature_compensation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  ptc_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output ptc_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int unsigned SIDE1_W = 32 + 19 + 2;
    localparam int unsigned SIDE2_W = 32 + 2;

    // Calibration registers
    logic [31:0] cal_ac1_ac2_reg, cal_ac3_ac4_reg, cal_ac5_ac6_reg;
    logic [31:0] cal_b1_b2_reg, cal_mc_md_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ac1_ac2_reg <= '0;
            cal_ac3_ac4_reg <= '0;
            cal_ac5_ac6_reg <= '0;
            cal_b1_b2_reg   <= '0;
            cal_mc_md_reg   <= '0;
            oss_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ptc_pkg::CFG_AC1_AC2: cal_ac1_ac2_reg <= cfg_data;
                ptc_pkg::CFG_AC3_AC4: cal_ac3_ac4_reg <= cfg_data;
                ptc_pkg::CFG_AC5_AC6: cal_ac5_ac6_reg <= cfg_data;
                ptc_pkg::CFG_B1_B2:   cal_b1_b2_reg   <= cfg_data;
                ptc_pkg::CFG_MC_MD:   cal_mc_md_reg   <= cfg_data;
                ptc_pkg::CFG_OSS:     oss_reg         <= cfg_data[1:0];
                default:              ; // drop writes beyond the register list
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    always_comb
    begin
        ac1 = ptc_pkg::sx16(cal_ac1_ac2_reg[31:16]);
        ac2 = ptc_pkg::sx16(cal_ac1_ac2_reg[15:0]);
        ac3 = ptc_pkg::sx16(cal_ac3_ac4_reg[31:16]);
        ac4 = {16'd0, cal_ac3_ac4_reg[15:0]};
        ac5 = {16'd0, cal_ac5_ac6_reg[31:16]};
        ac6 = {16'd0, cal_ac5_ac6_reg[15:0]};
        b1  = ptc_pkg::sx16(cal_b1_b2_reg[31:16]);
        b2  = ptc_pkg::sx16(cal_b1_b2_reg[15:0]);
        mc  = ptc_pkg::sx16(cal_mc_md_reg[31:16]);
        md  = ptc_pkg::sx16(cal_mc_md_reg[15:0]);
    end

    // Advance the whole pipeline unless a finished result is held back.
    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || !result_stall;
    assign sample_stall = !adv;

    // Valid flags of the plain stages
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic vh_reg, vi_reg, vj_reg, vk_reg, vl_reg;
    logic v1_done, v2_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            vg_reg        <= 1'b0;
            vh_reg        <= 1'b0;
            vi_reg        <= 1'b0;
            vj_reg        <= 1'b0;
            vk_reg        <= 1'b0;
            vl_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg        <= sample_valid;
            vb_reg        <= va_reg;
            vc_reg        <= v1_done;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            vf_reg        <= ve_reg;
            vg_reg        <= vf_reg;
            vh_reg        <= vg_reg;
            vi_reg        <= vh_reg;
            vj_reg        <= vi_reg;
            vk_reg        <= v2_done;
            vl_reg        <= vk_reg;
            out_valid_reg <= vl_reg;
        end
    end

    // Stage A: temperature product
    logic [31:0] a_prod_reg, a_prod_next;
    logic [18:0] a_up_reg;

    assign a_prod_next = 32'(({16'd0, sample.raw_temperature} - ac6) * ac5);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_prod_reg <= a_prod_next;
            a_up_reg   <= sample.raw_pressure;
        end
    end

    // Stage B: set up the first division mc*2^11 / (x1 + md) in sign-magnitude
    logic [31:0] b_x1_next, b_d, b_a, b_num_next, b_den_next;
    logic [31:0] b_x1_reg, b_num_reg, b_den_reg;
    logic [18:0] b_up_reg;
    logic        b_neg_reg, b_neg_next, b_err_reg, b_err_next;

    always_comb
    begin
        b_x1_next  = ptc_pkg::asr32(a_prod_reg, 15);
        b_d        = b_x1_next + md;
        b_a        = {mc[20:0], 11'd0};
        b_num_next = b_a[31] ? 32'(-b_a) : b_a;
        b_den_next = b_d[31] ? 32'(-b_d) : b_d;
        b_neg_next = b_a[31] ^ b_d[31];
        b_err_next = (b_d == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_x1_reg  <= b_x1_next;
            b_num_reg <= b_num_next;
            b_den_reg <= b_den_next;
            b_up_reg  <= a_up_reg;
            b_neg_reg <= b_neg_next;
            b_err_reg <= b_err_next;
        end
    end

    logic [31:0]        q1;
    logic [SIDE1_W-1:0] side1;

    ptc_divider #(.SIDE_W(SIDE1_W)) u_div_t (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .feed_valid (vb_reg),
        .feed_num   (b_num_reg),
        .feed_den   (b_den_reg),
        .feed_side  ({b_x1_reg, b_up_reg, b_neg_reg, b_err_reg}),
        .done_valid (v1_done),
        .done_quo   (q1),
        .done_side  (side1)
    );

    // Stage C: finish temperature, form b6
    logic [31:0] c_x1, c_x2, c_b5, c_t_next, c_b6_next;
    logic [31:0] c_t_reg, c_b6_reg;
    logic [18:0] c_up_reg;
    logic        c_err_reg;

    always_comb
    begin
        c_x1      = side1[SIDE1_W-1 -: 32];
        c_x2      = side1[1] ? 32'(-q1) : q1;
        c_b5      = c_x1 + c_x2;
        c_t_next  = ptc_pkg::asr32(c_b5 + 32'd8, 4);
        c_b6_next = c_b5 - ptc_pkg::T_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_t_reg   <= c_t_next;
            c_b6_reg  <= c_b6_next;
            c_up_reg  <= side1[20:2];
            c_err_reg <= side1[0];
        end
    end

    // Stage D: products of b6
    logic [31:0] d_sqp_reg, d_ac2p_reg, d_ac3p_reg, d_t_reg;
    logic [18:0] d_up_reg;
    logic        d_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_sqp_reg  <= 32'(c_b6_reg * c_b6_reg);
            d_ac2p_reg <= 32'(ac2 * c_b6_reg);
            d_ac3p_reg <= 32'(ac3 * c_b6_reg);
            d_t_reg    <= c_t_reg;
            d_up_reg   <= c_up_reg;
            d_err_reg  <= c_err_reg;
        end
    end

    // Stage E: scale the products
    logic [31:0] e_sq_reg, e_x2_reg, e_x1_reg, e_t_reg;
    logic [18:0] e_up_reg;
    logic        e_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_sq_reg  <= ptc_pkg::asr32(d_sqp_reg, 12);
            e_x2_reg  <= ptc_pkg::asr32(d_ac2p_reg, 11);
            e_x1_reg  <= ptc_pkg::asr32(d_ac3p_reg, 13);
            e_t_reg   <= d_t_reg;
            e_up_reg  <= d_up_reg;
            e_err_reg <= d_err_reg;
        end
    end

    // Stage F: b2 and b1 terms
    logic [31:0] f_m1_reg, f_m2_reg, f_x2_reg, f_x1_reg, f_t_reg;
    logic [18:0] f_up_reg;
    logic        f_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_m1_reg  <= 32'(b2 * e_sq_reg);
            f_m2_reg  <= 32'(b1 * e_sq_reg);
            f_x2_reg  <= e_x2_reg;
            f_x1_reg  <= e_x1_reg;
            f_t_reg   <= e_t_reg;
            f_up_reg  <= e_up_reg;
            f_err_reg <= e_err_reg;
        end
    end

    // Stage G: b3 (signed divide by four, toward zero) and x3 for b4
    logic [31:0] g_x3a, g_v, g_vmag, g_vq, g_b3_next, g_x3_next;
    logic [31:0] g_b3_reg, g_x3_reg, g_t_reg;
    logic [18:0] g_up_reg;
    logic        g_err_reg;

    always_comb
    begin
        g_x3a     = ptc_pkg::asr32(f_m1_reg, 11) + f_x2_reg;
        g_v       = ((32'(ac1 << 2) + g_x3a) << oss_reg) + 32'd2;
        g_vmag    = g_v[31] ? 32'(-g_v) : g_v;
        g_vq      = g_vmag >> 2;
        g_b3_next = g_v[31] ? 32'(-g_vq) : g_vq;
        g_x3_next = ptc_pkg::asr32(f_x1_reg + ptc_pkg::asr32(f_m2_reg, 16) + 32'd2, 2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_b3_reg  <= g_b3_next;
            g_x3_reg  <= g_x3_next;
            g_t_reg   <= f_t_reg;
            g_up_reg  <= f_up_reg;
            g_err_reg <= f_err_reg;
        end
    end

    // Stage H: b4 and the pressure difference
    logic [31:0] h_b4_reg, h_diff_reg, h_t_reg;
    logic        h_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_b4_reg   <= 32'(ac4 * (g_x3_reg + ptc_pkg::B4_OFFSET)) >> 15;
            h_diff_reg <= {13'd0, g_up_reg} - g_b3_reg;
            h_t_reg    <= g_t_reg;
            h_err_reg  <= g_err_reg;
        end
    end

    // Stage I: b7
    logic [31:0] i_b7_reg, i_b4_reg, i_t_reg;
    logic        i_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_b7_reg  <= 32'(h_diff_reg * (ptc_pkg::PRES_SCALE >> oss_reg));
            i_b4_reg  <= h_b4_reg;
            i_t_reg   <= h_t_reg;
            i_err_reg <= h_err_reg || (h_b4_reg == '0);
        end
    end

    // Stage J: set up the second division, doubling before or after it
    logic [31:0] j_num_reg, j_den_reg, j_t_reg;
    logic        j_dbl_reg, j_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_num_reg <= i_b7_reg[31] ? i_b7_reg : {i_b7_reg[30:0], 1'b0};
            j_den_reg <= i_b4_reg;
            j_dbl_reg <= i_b7_reg[31];
            j_t_reg   <= i_t_reg;
            j_err_reg <= i_err_reg;
        end
    end

    logic [31:0]        q2;
    logic [SIDE2_W-1:0] side2;

    ptc_divider #(.SIDE_W(SIDE2_W)) u_div_p (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .feed_valid (vj_reg),
        .feed_num   (j_num_reg),
        .feed_den   (j_den_reg),
        .feed_side  ({j_t_reg, j_dbl_reg, j_err_reg}),
        .done_valid (v2_done),
        .done_quo   (q2),
        .done_side  (side2)
    );

    // Stage K: pressure and its correction products
    logic [31:0] k_p, k_s;
    logic [31:0] k_p_reg, k_s2_reg, k_m7357_reg, k_t_reg;
    logic        k_err_reg;

    always_comb
    begin
        k_p = side2[1] ? {q2[30:0], 1'b0} : q2;
        k_s = ptc_pkg::asr32(k_p, 8);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_p_reg     <= k_p;
            k_s2_reg    <= 32'(k_s * k_s);
            k_m7357_reg <= 32'(ptc_pkg::K_M7357 * k_p);
            k_t_reg     <= side2[SIDE2_W-1 -: 32];
            k_err_reg   <= side2[0];
        end
    end

    // Stage L
    logic [31:0] l_p_reg, l_m3038_reg, l_x2_reg, l_t_reg;
    logic        l_err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_p_reg     <= k_p_reg;
            l_m3038_reg <= 32'(k_s2_reg * ptc_pkg::K_3038);
            l_x2_reg    <= ptc_pkg::asr32(k_m7357_reg, 16);
            l_t_reg     <= k_t_reg;
            l_err_reg   <= k_err_reg;
        end
    end

    // Output stage: final correction, saturation and status
    logic [31:0]      m_sum, m_p;
    logic [15:0]      m_t;
    ptc_pkg::result_t out_next, out_reg;

    always_comb
    begin
        m_sum = ptc_pkg::asr32(l_m3038_reg, 16) + l_x2_reg + ptc_pkg::K_3791;
        m_p   = l_p_reg + ptc_pkg::asr32(m_sum, 4);

        if ($signed(l_t_reg) < $signed(ptc_pkg::T_MIN))
            m_t = ptc_pkg::T_MIN[15:0];
        else if ($signed(l_t_reg) > $signed(ptc_pkg::T_MAX))
            m_t = ptc_pkg::T_MAX[15:0];
        else
            m_t = l_t_reg[15:0];

        out_next.temperature_tenths = m_t;
        out_next.status             = ptc_pkg::ST_OK;
        if (m_p[31])
        begin
            out_next.pressure_pa = '0;
            out_next.status      = ptc_pkg::ST_SAT;
        end
        else if (m_p > ptc_pkg::P_MAX)
        begin
            out_next.pressure_pa = ptc_pkg::P_MAX[19:0];
            out_next.status      = ptc_pkg::ST_SAT;
        end
        else
        begin
            out_next.pressure_pa = m_p[19:0];
        end

        // Zero divisor in either division: zero both readings
        if (l_err_reg)
        begin
            out_next.temperature_tenths = '0;
            out_next.pressure_pa        = '0;
            out_next.status             = ptc_pkg::ST_DIV0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hw/rtl/ptc_div_cell.sv */
// One restoring-division cell: settles one quotient bit and hands the remainder on.
// Depends on ptc_pkg for the datapath width.
module ptc_div_cell #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          up_valid,
    input  logic [ptc_pkg::DIV_W-1:0]     up_rem,
    input  logic [ptc_pkg::DIV_W-1:0]     up_num,
    input  logic [ptc_pkg::DIV_W-1:0]     up_den,
    input  logic [ptc_pkg::DIV_W-1:0]     up_quo,
    input  logic [SIDE_W-1:0]             up_side,
    output logic                          dn_valid,
    output logic [ptc_pkg::DIV_W-1:0]     dn_rem,
    output logic [ptc_pkg::DIV_W-1:0]     dn_num,
    output logic [ptc_pkg::DIV_W-1:0]     dn_den,
    output logic [ptc_pkg::DIV_W-1:0]     dn_quo,
    output logic [SIDE_W-1:0]             dn_side
);

    logic                      valid_reg;
    logic [ptc_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [ptc_pkg::DIV_W-1:0] num_reg, den_reg, quo_reg, quo_next;
    logic [SIDE_W-1:0]         side_reg;
    logic [ptc_pkg::DIV_W:0]   trial;
    logic [ptc_pkg::DIV_W:0]   diff;
    logic                      ge;

    always_comb
    begin
        trial    = {up_rem, up_num[ptc_pkg::DIV_W-1]};
        diff     = trial - {1'b0, up_den};
        ge       = (trial >= {1'b0, up_den});
        rem_next = ge ? diff[ptc_pkg::DIV_W-1:0] : trial[ptc_pkg::DIV_W-1:0];
        quo_next = {up_quo[ptc_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {up_num[ptc_pkg::DIV_W-2:0], 1'b0};
            den_reg  <= up_den;
            quo_reg  <= quo_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_num   = num_reg;
    assign dn_den   = den_reg;
    assign dn_quo   = quo_reg;
    assign dn_side  = side_reg;

endmodule

/* hw/rtl/ptc_divider.sv */
// Pipelined unsigned divider built as a chain of ptc_div_cell, one quotient bit per cell.
// Depends on ptc_pkg and ptc_div_cell.
module ptc_divider #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      feed_valid,
    input  logic [ptc_pkg::DIV_W-1:0] feed_num,
    input  logic [ptc_pkg::DIV_W-1:0] feed_den,
    input  logic [SIDE_W-1:0]         feed_side,
    output logic                      done_valid,
    output logic [ptc_pkg::DIV_W-1:0] done_quo,
    output logic [SIDE_W-1:0]         done_side
);

    localparam int unsigned N = ptc_pkg::DIV_W;

    logic                      v_c   [0:N];
    logic [ptc_pkg::DIV_W-1:0] rem_c [0:N];
    logic [ptc_pkg::DIV_W-1:0] num_c [0:N];
    logic [ptc_pkg::DIV_W-1:0] den_c [0:N];
    logic [ptc_pkg::DIV_W-1:0] quo_c [0:N];
    logic [SIDE_W-1:0]         side_c[0:N];

    assign v_c[0]    = feed_valid;
    assign rem_c[0]  = '0;
    assign num_c[0]  = feed_num;
    assign den_c[0]  = feed_den;
    assign quo_c[0]  = '0;
    assign side_c[0] = feed_side;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ptc_div_cell #(.SIDE_W(SIDE_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (v_c[k]),
            .up_rem   (rem_c[k]),
            .up_num   (num_c[k]),
            .up_den   (den_c[k]),
            .up_quo   (quo_c[k]),
            .up_side  (side_c[k]),
            .dn_valid (v_c[k+1]),
            .dn_rem   (rem_c[k+1]),
            .dn_num   (num_c[k+1]),
            .dn_den   (den_c[k+1]),
            .dn_quo   (quo_c[k+1]),
            .dn_side  (side_c[k+1])
        );
    end

    assign done_valid = v_c[N];
    assign done_quo   = quo_c[N];
    assign done_side  = side_c[N];

endmodule
